@@ rtl/core/vdi_pkg.sv @@
// Shared constants and float-equality helper for the vertex dedup indexer.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package vdi_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int FIELD_W          = 32;
    localparam int CORNER_W         = 5 * FIELD_W;
    localparam int INDEX_OUT_W      = 10;
    localparam int COUNT_OUT_W      = 11;
    localparam int RES_DATA_W       = 24;   // index + count, padded to bytes
    localparam int RES_USER_W       = 2;

    // bit positions in m_tuser
    localparam int USER_NEW_BIT  = 0;
    localparam int USER_FULL_BIT = 1;

    localparam logic [FIELD_W-1:0] ABS_MASK = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] INF_BITS = 32'h7F80_0000;

    // float equality on raw patterns: NaN never equal, +0 == -0
    function automatic logic feq32(input logic [FIELD_W-1:0] a,
                                   input logic [FIELD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic zeros;
        a_nan = (a & ABS_MASK) > INF_BITS;
        b_nan = (b & ABS_MASK) > INF_BITS;
        zeros = ((a | b) & ABS_MASK) == '0;
        return !a_nan && !b_nan && ((a == b) || zeros);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/vdi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/vertex_dedup_indexer.sv @@
// Vertex welding indexer: one corner in, one index out. Uses vdi_pkg, vdi_ram.
// Sequence: an accepted corner is compared against the table from entry 0,
//   one entry a cycle over the single table read port, up to the first match
//   or the last stored entry; the result register is then loaded in ST_DONE
//   once the output is free, appending an unmatched corner if there is room.
// Throughput: one corner at a time; the next is taken the cycle after the
//   result is registered, even while that result still waits on m_tready.
// Reset (aresetn low, synchronous): control and count cleared, table RAM not
//   touched; entries at or above the count are never read.
`default_nettype none

module vertex_dedup_indexer
    import vdi_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input corner channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [CORNER_W-1:0]   s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
    input  wire logic                  s_tuser,   // mesh_start
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [RES_DATA_W-1:0]      m_tdata,   // vertex_index[9:0], unique_count[20:10], pad
    output logic [RES_USER_W-1:0]      m_tuser    // new_vertex, table_full
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,    // walk the table, one read issued and one compared per cycle
        ST_DONE     // append or flag full, load the result register
    } state_t;

    state_t                 state_reg, state_next;
    logic [CORNER_W-1:0]    corner_reg, corner_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          scan_reg, scan_next;     // next entry to read
    logic                   pend_reg, pend_next;     // a read is in flight
    logic [AW-1:0]          pend_idx_reg, pend_idx_next;
    logic                   found_reg, found_next;
    logic [AW-1:0]          hit_idx_reg, hit_idx_next;

    logic                   m_valid_reg, m_valid_next;
    logic [RES_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [RES_USER_W-1:0]  m_user_reg, m_user_next;

    logic                   rd_en;
    logic [CORNER_W-1:0]    rd_data;
    logic                   wr_en;
    logic                   hit;
    logic                   out_free;
    logic [AW-1:0]          res_idx;
    logic                   res_new;
    logic                   res_full;
    logic [CW-1:0]          res_count;
    logic [AW+INDEX_OUT_W-1:0] idx_ext;
    logic [CW+COUNT_OUT_W-1:0] cnt_ext;

    // The table is touched only by the current corner, and the append is the
    // last access of its sequence, so no read can overlap a write to the
    // same entry: the sequencer itself is the interlock.
    vdi_ram #(
        .WIDTH (CORNER_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (corner_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // all five fields float-equal
    assign hit = pend_reg
        && feq32(rd_data[0*FIELD_W +: FIELD_W], corner_reg[0*FIELD_W +: FIELD_W])
        && feq32(rd_data[1*FIELD_W +: FIELD_W], corner_reg[1*FIELD_W +: FIELD_W])
        && feq32(rd_data[2*FIELD_W +: FIELD_W], corner_reg[2*FIELD_W +: FIELD_W])
        && feq32(rd_data[3*FIELD_W +: FIELD_W], corner_reg[3*FIELD_W +: FIELD_W])
        && feq32(rd_data[4*FIELD_W +: FIELD_W], corner_reg[4*FIELD_W +: FIELD_W]);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign rd_en    = (state_reg == ST_SCAN) && !hit && (scan_reg < count_reg);

    // result decision in ST_DONE
    always_comb begin
        res_new   = 1'b0;
        res_full  = 1'b0;
        res_idx   = hit_idx_reg;
        res_count = count_reg;
        if (!found_reg) begin
            if (count_reg < MAX_CNT) begin
                res_new   = 1'b1;
                res_idx   = count_reg[AW-1:0];
                res_count = CW'(count_reg + 1'b1);
            end else begin
                res_full = 1'b1;
                res_idx  = '0;
            end
        end
    end

    assign wr_en   = (state_reg == ST_DONE) && out_free && res_new;
    assign idx_ext = {{INDEX_OUT_W{1'b0}}, res_idx};
    assign cnt_ext = {{COUNT_OUT_W{1'b0}}, res_count};

    always_comb begin
        state_next    = state_reg;
        corner_next   = corner_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    corner_next = s_tdata;
                    if (s_tuser) begin
                        count_next = '0;       // start of a new mesh
                    end
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (hit) begin
                    found_next   = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    state_next   = ST_DONE;
                end else if (scan_reg < count_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[AW-1:0];
                    scan_next     = CW'(scan_reg + 1'b1);
                end else begin
                    // every entry read and the last compare missed
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    count_next   = res_count;
                    m_valid_next = 1'b1;
                    m_data_next  = RES_DATA_W'({cnt_ext[COUNT_OUT_W-1:0],
                                                idx_ext[INDEX_OUT_W-1:0]});
                    m_user_next  = {res_full, res_new};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        corner_reg   <= corner_next;
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        hit_idx_reg  <= hit_idx_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

@@ rtl/core/vdi_checker.sv @@
// Port-level checks on the vertex dedup indexer, bound to the top level.
// Uses vdi_pkg; attaches to vertex_dedup_indexer.
`default_nettype none

module vdi_checker
    import vdi_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [RES_DATA_W-1:0] m_tdata,
    input wire logic [RES_USER_W-1:0] m_tuser
);

    logic [INDEX_OUT_W-1:0] res_idx;
    logic [COUNT_OUT_W-1:0] res_cnt;
    logic [COUNT_OUT_W-1:0] cnt_less;

    assign res_idx  = m_tdata[INDEX_OUT_W-1:0];
    assign res_cnt  = m_tdata[INDEX_OUT_W +: COUNT_OUT_W];
    assign cnt_less = COUNT_OUT_W'(res_cnt - 1'b1);

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // appended and full never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[USER_NEW_BIT] && m_tuser[USER_FULL_BIT]))
        else $error("new vertex and table full both set");

    // full table returns index zero
    a_full_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_FULL_BIT] |-> res_idx == '0)
        else $error("full table with nonzero index");

    // an appended vertex is the last entry
    a_new_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_NEW_BIT] |-> res_idx == cnt_less[INDEX_OUT_W-1:0])
        else $error("new vertex index does not match count");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
